>>> src/beacon_vendor_element_finder_macros.svh
// Assertion helpers for the beacon vendor element finder.
`ifndef BEACON_VENDOR_ELEMENT_FINDER_MACROS_SVH
`define BEACON_VENDOR_ELEMENT_FINDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BVEF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BVEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bvef_pkg.sv
package bvef_pkg;

  localparam int FRAME_LIMIT = 4096;
  // position counter must reach FRAME_LIMIT itself
  localparam int POS_W = $clog2(FRAME_LIMIT) + 1;
  // element start can sit at elements_start (8 bits) or past FRAME_LIMIT
  localparam int NXT_W = (POS_W > 9) ? POS_W : 9;

  localparam logic [7:0] VENDOR_ID      = 8'hDD;
  localparam logic [7:0] MIN_VENDOR_LEN = 8'd5;
  localparam logic [7:0] HEADER_SKIP    = 8'd4;
  localparam logic [3:0] PAYLOAD_SKIP   = 4'd6;

  localparam logic [7:0] PAYLOAD_LIMIT_RST  = 8'd250;
  localparam logic [7:0] ELEMENTS_START_RST = 8'd36;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [0:0] {
    REG_PAYLOAD_LIMIT  = 1'b0,
    REG_ELEMENTS_START = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    OUT_FOUND   = 3'd0,
    OUT_NONE    = 3'd1,
    OUT_OVERRUN = 3'd2,
    OUT_LIMIT   = 3'd3,
    OUT_LONG    = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    PH_ID   = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] payload_limit;
    logic [7:0] elements_start;
  } cfg_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [11:0] payload_offset;
    logic [7:0]  payload_length;
  } result_t;

  // vendor OUI followed by the element type
  function automatic logic [7:0] vendor_prefix(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'hFA;
      2'd1:    b = 8'h0B;
      2'd2:    b = 8'hBC;
      default: b = 8'h0D;
    endcase
    return b;
  endfunction

endpackage

>>> src/bvef_cfg_regs.sv
module bvef_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bvef_pkg::ADDR_W-1:0]   paddr,
  input  logic [bvef_pkg::DATA_W-1:0]   pwdata,
  output logic [bvef_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output bvef_pkg::cfg_t                cfg_o
);
  import bvef_pkg::*;

  logic       wr_en;
  reg_idx_e   idx;
  cfg_t       cfg_q;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.payload_limit  <= PAYLOAD_LIMIT_RST;
      cfg_q.elements_start <= ELEMENTS_START_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PAYLOAD_LIMIT:  cfg_q.payload_limit  <= pwdata[7:0];
        REG_ELEMENTS_START: cfg_q.elements_start <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PAYLOAD_LIMIT:  prdata = {{(DATA_W-8){1'b0}}, cfg_q.payload_limit};
      REG_ELEMENTS_START: prdata = {{(DATA_W-8){1'b0}}, cfg_q.elements_start};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/bvef_walker.sv
module bvef_walker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              end_i,
  input  bvef_pkg::cfg_t    cfg_i,
  output bvef_pkg::result_t result_o
);
  import bvef_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             ovf_q, ovf_d;
  logic [NXT_W-1:0] nxt_q, nxt_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       kind_q, kind_d;
  logic [7:0]       size_q, size_d;
  logic             match_q, match_d;
  logic             decided_q, decided_d;
  outcome_e         hout_q, hout_d;
  logic [11:0]      hoff_q, hoff_d;
  logic [7:0]       hlen_q, hlen_d;

  logic [NXT_W-1:0] pos_ext;
  logic [NXT_W-1:0] body_idx;
  logic             done;
  logic [7:0]       body_len;
  logic [NXT_W-1:0] off_full;

  assign pos_ext  = NXT_W'(pos_q);
  assign body_idx = pos_ext - nxt_q - NXT_W'(2);
  assign off_full = nxt_q + NXT_W'(PAYLOAD_SKIP);

  always_comb begin
    pos_d     = pos_q;
    ovf_d     = ovf_q;
    nxt_d     = nxt_q;
    phase_d   = phase_q;
    kind_d    = kind_q;
    size_d    = size_q;
    match_d   = match_q;
    decided_d = decided_q;
    hout_d    = hout_q;
    hoff_d    = hoff_q;
    hlen_d    = hlen_q;
    done      = 1'b0;
    body_len  = '0;

    result_o.outcome        = OUT_NONE;
    result_o.payload_offset = '0;
    result_o.payload_length = '0;

    if (step_i) begin
      if (pos_q >= POS_W'(FRAME_LIMIT)) begin
        ovf_d = 1'b1;
      end else begin
        pos_d = pos_q + POS_W'(1);
        if (!decided_q && (pos_ext >= nxt_q)) begin
          unique case (phase_q)
            PH_ID: begin
              kind_d  = byte_i;
              phase_d = PH_LEN;
            end
            PH_LEN: begin
              size_d  = byte_i;
              match_d = (kind_q == VENDOR_ID) && (byte_i >= MIN_VENDOR_LEN);
              phase_d = PH_BODY;
              done    = (byte_i == 8'd0);
            end
            PH_BODY: begin
              if ((body_idx < NXT_W'(4)) && (byte_i != vendor_prefix(body_idx[1:0])))
                match_d = 1'b0;
              done = ((body_idx + NXT_W'(1)) == NXT_W'(size_q));
            end
            default: ;
          endcase

          // element complete: either the match decides or the walk moves on
          if (done) begin
            if (match_d) begin
              body_len  = size_d - HEADER_SKIP;
              decided_d = 1'b1;
              if (body_len > cfg_i.payload_limit) begin
                hout_d = OUT_LIMIT;
              end else begin
                hout_d = OUT_FOUND;
                hoff_d = off_full[11:0];
                hlen_d = body_len;
              end
            end else begin
              nxt_d   = nxt_q + NXT_W'(2) + NXT_W'(size_d);
              phase_d = PH_ID;
            end
          end
        end
      end

      if (end_i) begin
        priority if (decided_d) begin
          result_o.outcome        = hout_d;
          result_o.payload_offset = hoff_d;
          result_o.payload_length = hlen_d;
        end else if (ovf_d) begin
          result_o.outcome = OUT_LONG;
        end else if (phase_d == PH_BODY) begin
          result_o.outcome = OUT_OVERRUN;
        end else begin
          result_o.outcome = OUT_NONE;
        end

        // start of a new frame
        pos_d     = '0;
        ovf_d     = 1'b0;
        nxt_d     = NXT_W'(cfg_i.elements_start);
        phase_d   = PH_ID;
        kind_d    = '0;
        size_d    = '0;
        match_d   = 1'b0;
        decided_d = 1'b0;
        hout_d    = OUT_NONE;
        hoff_d    = '0;
        hlen_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      ovf_q     <= 1'b0;
      nxt_q     <= NXT_W'(ELEMENTS_START_RST);
      phase_q   <= PH_ID;
      kind_q    <= '0;
      size_q    <= '0;
      match_q   <= 1'b0;
      decided_q <= 1'b0;
      hout_q    <= OUT_NONE;
      hoff_q    <= '0;
      hlen_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      ovf_q     <= ovf_d;
      nxt_q     <= nxt_d;
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      size_q    <= size_d;
      match_q   <= match_d;
      decided_q <= decided_d;
      hout_q    <= hout_d;
      hoff_q    <= hoff_d;
      hlen_q    <= hlen_d;
    end
  end

endmodule

>>> src/beacon_vendor_element_finder.sv
// channel  | direction | valid / stall                  | payload
// frame    | in        | frame_valid_i / frame_stall_o  | frame_byte_i, frame_end_i
// result   | out       | result_valid_o / result_stall_i| outcome_o, payload_offset_o,
//          |           |                                | payload_length_o
// config   | in        | APB psel/penable/pwrite        | paddr, pwdata, prdata
//
// One byte per cycle unless an end byte waits on the output: each byte is held in
// the input register; walker element state and result register update in the same cycle.
// A frame's result is registered when its last byte leaves the input register.
// Reset clears the valid flags and walker state and loads the config register defaults.
// A waiting result stalls the input only when the held byte ends a frame too.
`include "beacon_vendor_element_finder_macros.svh"

module beacon_vendor_element_finder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         frame_valid_i,
  output logic                         frame_stall_o,
  input  logic [7:0]                   frame_byte_i,
  input  logic                         frame_end_i,
  output logic                         result_valid_o,
  input  logic                         result_stall_i,
  output logic [2:0]                   outcome_o,
  output logic [11:0]                  payload_offset_o,
  output logic [7:0]                   payload_length_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bvef_pkg::ADDR_W-1:0]  paddr,
  input  logic [bvef_pkg::DATA_W-1:0]  pwdata,
  output logic [bvef_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import bvef_pkg::*;

  cfg_t       cfg;
  result_t    res;
  result_t    res_q;

  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       end_q;
  logic       accept;
  logic       advance;
  logic       out_free;
  logic       out_vld_q, out_vld_d;

  assign out_free      = !out_vld_q || !result_stall_i;
  // bytes that give no result never wait for the output side
  assign advance       = in_vld_q && (!end_q || out_free);
  assign frame_stall_o = in_vld_q && !advance;
  assign accept        = frame_valid_i && !frame_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept)       in_vld_d = 1'b1;
    else if (advance) in_vld_d = 1'b0;

    out_vld_d = out_vld_q;
    if (advance && end_q) out_vld_d = 1'b1;
    else if (!result_stall_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= frame_byte_i;
      end_q  <= frame_end_i;
    end
    if (advance && end_q) res_q <= res;
  end

  bvef_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bvef_walker u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (byte_q),
    .end_i    (end_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  assign result_valid_o   = out_vld_q;
  assign outcome_o        = res_q.outcome;
  assign payload_offset_o = res_q.payload_offset;
  assign payload_length_o = res_q.payload_length;

  `BVEF_ASSERT_NEXT(a_result_from_end, advance && end_q, result_valid_o,
                    "end byte gave no result")
  `BVEF_ASSERT_NOW(a_zero_unless_found, result_valid_o && (outcome_o != OUT_FOUND),
                   (payload_offset_o == 12'd0) && (payload_length_o == 8'd0),
                   "payload fields set without a match")
  `BVEF_ASSERT_NEXT(a_held_byte_kept, in_vld_q && !advance,
                    in_vld_q && $stable(byte_q) && $stable(end_q), "held byte overwritten")

endmodule
